// ----- src/tpc_pkg.sv -----
// ---------------------------------------------------------------------------
// tpc_pkg
// Widths and stage counts shared by the three point curvature pipeline.
// ---------------------------------------------------------------------------
package tpc_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int CURV_FRAC_BITS  = 16;

    localparam int XY_W    = 32;               // input coordinate
    localparam int DIFF_W  = XY_W + 1;         // coordinate difference
    localparam int SQ_W    = 2 * XY_W + 1;     // square of a difference
    localparam int SUM_W   = SQ_W + 1;         // sum of two squares
    localparam int CROSS_W = 2 * DIFF_W;       // signed cross product term
    localparam int CABS_W  = SUM_W;            // magnitude of the cross product

    localparam int SQ_STAGES = (SUM_W + 1) / 2;   // one root bit per stage
    localparam int ROOT_W    = SQ_STAGES;
    localparam int RAD_W     = 2 * SQ_STAGES;
    localparam int REM_W     = ROOT_W + 2;

    localparam int PROD_W = 2 * ROOT_W;           // d12 * d23
    localparam int DEN_W  = 3 * ROOT_W;           // d12 * d23 * d13

    localparam int NUM_SHIFT = 1 + COORD_FRAC_BITS + CURV_FRAC_BITS;
    localparam int NUM_W     = CABS_W + NUM_SHIFT;

    localparam int Q_W        = 32;
    localparam int CMP_W      = DEN_W + Q_W;
    localparam int DIV_STAGES = Q_W + 1;          // saturation check, then one bit a stage

    localparam int FRONT_STAGES = 3;
    localparam int DEN_STAGES   = 3;
    localparam int PIPE_LEN     = FRONT_STAGES + SQ_STAGES + DEN_STAGES + DIV_STAGES;
    localparam int CABS_DLY     = SQ_STAGES + DEN_STAGES;
    localparam int DG_LEN       = PIPE_LEN - FRONT_STAGES;

endpackage

// ----- src/tpc_sqrt.sv -----
// ---------------------------------------------------------------------------
// tpc_sqrt
// Pipelined integer square root, floor(sqrt(s)), one root bit per stage.
// ---------------------------------------------------------------------------
module tpc_sqrt (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [tpc_pkg::SUM_W-1:0]    i_s,
    output logic [tpc_pkg::ROOT_W-1:0]   o_root
);

    localparam int N  = tpc_pkg::SQ_STAGES;
    localparam int RW = tpc_pkg::REM_W;
    localparam int TW = tpc_pkg::ROOT_W;
    localparam int AW = tpc_pkg::RAD_W;

    logic [RW-1:0] r_rem  [N];
    logic [TW-1:0] r_root [N];
    logic [AW-1:0] r_rad  [N];

    for (genvar g = 0; g < N; g++) begin : g_stage
        logic [RW-1:0] rem_in;
        logic [TW-1:0] root_in;
        logic [AW-1:0] rad_in;
        logic [RW+1:0] rem_sh;
        logic [RW+1:0] trial;
        logic          ge;

        if (g == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = AW'(i_s);
        end else begin : g_next
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
            assign rad_in  = r_rad[g-1];
        end

        // bring down the next two radicand bits and try root*4+1
        assign rem_sh = {rem_in, rad_in[AW-1 -: 2]};
        assign trial  = (RW+2)'({root_in, 2'b01});
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= ge ? RW'(rem_sh - trial) : RW'(rem_sh);
                r_root[g] <= {root_in[TW-2:0], ge};
                r_rad[g]  <= {rad_in[AW-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[N-1];

endmodule

// ----- src/tpc_div.sv -----
// ---------------------------------------------------------------------------
// tpc_div
// Pipelined restoring divider, one quotient bit per stage, saturating.
// ---------------------------------------------------------------------------
module tpc_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [tpc_pkg::NUM_W-1:0]   i_num,
    input  logic [tpc_pkg::DEN_W-1:0]   i_den,
    output logic [tpc_pkg::Q_W-1:0]     o_q
);

    localparam int QW = tpc_pkg::Q_W;
    localparam int NW = tpc_pkg::NUM_W;
    localparam int DW = tpc_pkg::DEN_W;
    localparam int CW = tpc_pkg::CMP_W;

    // saturation check stage
    logic          r_sat0;
    logic [NW-1:0] r_num0;
    logic [DW-1:0] r_den0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat0 <= (CW'(i_num) >= (CW'(i_den) << QW));
            r_num0 <= i_num;
            r_den0 <= i_den;
        end
    end

    logic [NW-1:0] r_num [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_q   [QW];
    logic          r_sat [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic [NW-1:0] num_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] q_in;
        logic          sat_in;
        logic [CW-1:0] t;
        logic          ge;

        if (g == 0) begin : g_first
            assign num_in = r_num0;
            assign den_in = r_den0;
            assign q_in   = '0;
            assign sat_in = r_sat0;
        end else begin : g_next
            assign num_in = r_num[g-1];
            assign den_in = r_den[g-1];
            assign q_in   = r_q[g-1];
            assign sat_in = r_sat[g-1];
        end

        assign t  = CW'(den_in) << (QW - 1 - g);
        assign ge = (CW'(num_in) >= t);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[g] <= ge ? NW'(CW'(num_in) - t) : num_in;
                r_den[g] <= den_in;
                r_q[g]   <= {q_in[QW-2:0], ge};
                r_sat[g] <= sat_in;
            end
        end
    end

    assign o_q = r_sat[QW-1] ? '1 : r_q[QW-1];

endmodule

// ----- src/three_point_curvature_top.sv -----
// ---------------------------------------------------------------------------
// three_point_curvature_top
// Menger curvature of three planar points in a fully pipelined datapath.
// ---------------------------------------------------------------------------
// Input stream s_axis: one item is a point triple, tdata holds first_x,
// first_y, second_x, second_y, third_x, third_y, 32 bits each, lowest first.
// Output stream m_axis: tdata holds the curvature (unsigned, 16 fraction
// bits, saturating), tuser the degenerate flag (two points coincide, the
// curvature is then 0).
// Throughput: one item per cycle while m_axis does not stall. The item passes
// 73 registers on its way to m_axis_tvalid: 3 front-end stages
// (differences, squares and cross product, sums), 33 square root stages (one
// root bit each), 3 stages for the side length product, one saturation stage
// and 32 divider stages (one quotient bit each), plus the output register.
// The whole pipeline advances while the output register is empty or taken;
// while m_axis stalls with a result held, every stage holds and s_axis_tready
// is low, so no item is lost or repeated.
// Reset (synchronous, active low) clears all valid bits; data in flight is
// dropped.
// ---------------------------------------------------------------------------
module three_point_curvature_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // first_x, first_y, second_x, second_y, third_x, third_y
    input  logic [191:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // curvature
    output logic [31:0]   m_axis_tdata,
    // degenerate
    output logic          m_axis_tuser
);

    localparam int XW = tpc_pkg::XY_W;
    localparam int DF = tpc_pkg::DIFF_W;
    localparam int SQ = tpc_pkg::SQ_W;
    localparam int SM = tpc_pkg::SUM_W;
    localparam int CR = tpc_pkg::CROSS_W;
    localparam int CA = tpc_pkg::CABS_W;
    localparam int RT = tpc_pkg::ROOT_W;
    localparam int PW = tpc_pkg::PROD_W;
    localparam int DW = tpc_pkg::DEN_W;
    localparam int NL = tpc_pkg::PIPE_LEN;
    localparam int CD = tpc_pkg::CABS_DLY;
    localparam int GL = tpc_pkg::DG_LEN;

    logic w_en;
    assign w_en          = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = w_en;

    logic [XW-1:0] w_x1, w_y1, w_x2, w_y2, w_x3, w_y3;
    assign w_x1 = s_axis_tdata[0*XW +: XW];
    assign w_y1 = s_axis_tdata[1*XW +: XW];
    assign w_x2 = s_axis_tdata[2*XW +: XW];
    assign w_y2 = s_axis_tdata[3*XW +: XW];
    assign w_x3 = s_axis_tdata[4*XW +: XW];
    assign w_y3 = s_axis_tdata[5*XW +: XW];

    // stage 1: differences
    logic signed [DF-1:0] r_a12x, r_a12y, r_a23x, r_a23y, r_a13x, r_a13y;
    logic signed [DF-1:0] r_ux, r_uy, r_vx, r_vy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a12x <= {w_x1[XW-1], w_x1} - {w_x2[XW-1], w_x2};
            r_a12y <= {w_y1[XW-1], w_y1} - {w_y2[XW-1], w_y2};
            r_a23x <= {w_x2[XW-1], w_x2} - {w_x3[XW-1], w_x3};
            r_a23y <= {w_y2[XW-1], w_y2} - {w_y3[XW-1], w_y3};
            r_a13x <= {w_x1[XW-1], w_x1} - {w_x3[XW-1], w_x3};
            r_a13y <= {w_y1[XW-1], w_y1} - {w_y3[XW-1], w_y3};
            r_ux   <= {w_x2[XW-1], w_x2} - {w_x1[XW-1], w_x1};
            r_uy   <= {w_y2[XW-1], w_y2} - {w_y1[XW-1], w_y1};
            r_vx   <= {w_x3[XW-1], w_x3} - {w_x1[XW-1], w_x1};
            r_vy   <= {w_y3[XW-1], w_y3} - {w_y1[XW-1], w_y1};
        end
    end

    // stage 2: squares and cross product terms
    logic [SQ-1:0]        r_q12x, r_q12y, r_q23x, r_q23y, r_q13x, r_q13y;
    logic signed [CR-1:0] r_m1, r_m2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_q12x <= SQ'(r_a12x * r_a12x);
            r_q12y <= SQ'(r_a12y * r_a12y);
            r_q23x <= SQ'(r_a23x * r_a23x);
            r_q23y <= SQ'(r_a23y * r_a23y);
            r_q13x <= SQ'(r_a13x * r_a13x);
            r_q13y <= SQ'(r_a13y * r_a13y);
            r_m1   <= CR'(r_ux * r_vy);
            r_m2   <= CR'(r_uy * r_vx);
        end
    end

    // stage 3: squared side lengths, |cross|, coincident points
    logic [SM-1:0] w_s12, w_s23, w_s13;
    assign w_s12 = SM'(r_q12x) + SM'(r_q12y);
    assign w_s23 = SM'(r_q23x) + SM'(r_q23y);
    assign w_s13 = SM'(r_q13x) + SM'(r_q13y);

    logic [SM-1:0] r_s12, r_s23, r_s13;
    logic [CA-1:0] r_cabs;
    logic          r_dg3;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s12  <= w_s12;
            r_s23  <= w_s23;
            r_s13  <= w_s13;
            r_cabs <= (r_m1 >= r_m2) ? CA'(r_m1 - r_m2) : CA'(r_m2 - r_m1);
            r_dg3  <= (r_q12x == '0 && r_q12y == '0) || (r_q23x == '0 && r_q23y == '0)
                   || (r_q13x == '0 && r_q13y == '0);
        end
    end

    // side lengths
    logic [RT-1:0] w_d12, w_d23, w_d13;

    tpc_sqrt u_sqrt12 (.i_clk(i_clk), .i_en(w_en), .i_s(r_s12), .o_root(w_d12));
    tpc_sqrt u_sqrt23 (.i_clk(i_clk), .i_en(w_en), .i_s(r_s23), .o_root(w_d23));
    tpc_sqrt u_sqrt13 (.i_clk(i_clk), .i_en(w_en), .i_s(r_s13), .o_root(w_d13));

    // side length product, the wide multiply split in two halves
    logic [PW-1:0] r_p, r_lo, r_hi;
    logic [RT-1:0] r_d13_p1;
    logic [DW-1:0] r_den;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p      <= PW'(w_d12 * w_d23);
            r_d13_p1 <= w_d13;
            r_lo     <= PW'(r_p[RT-1:0] * r_d13_p1);
            r_hi     <= PW'(r_p[PW-1:RT] * r_d13_p1);
            r_den    <= DW'(r_lo) + (DW'(r_hi) << RT);
        end
    end

    // |cross| travels alongside the root and product stages
    logic [CA-1:0] r_cd [CD];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cd[0] <= r_cabs;
            for (int k = 1; k < CD; k++) begin
                r_cd[k] <= r_cd[k-1];
            end
        end
    end

    logic [tpc_pkg::NUM_W-1:0] w_num;
    logic [tpc_pkg::Q_W-1:0]   w_q;
    assign w_num = {r_cd[CD-1], {tpc_pkg::NUM_SHIFT{1'b0}}};

    tpc_div u_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_num),
        .i_den (r_den),
        .o_q   (w_q)
    );

    // valid and degenerate flags follow the items
    logic [NL-1:0] r_vld;
    logic [GL-1:0] r_dg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NL-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dg <= {r_dg[GL-2:0], r_dg3};
        end
    end

    // output register
    logic          r_out_vld;
    logic [31:0]   r_out_curv;
    logic          r_out_dg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_vld[NL-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_curv <= r_dg[GL-1] ? '0 : w_q;
            r_out_dg   <= r_dg[GL-1];
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_curv;
    assign m_axis_tuser  = r_out_dg;

    // a degenerate item never carries a curvature
    a_dg_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("degenerate item with nonzero curvature");

    // nothing comes out right after reset
    a_rst_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // the pipeline only holds while a result waits at the output
    a_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // a held result stays unchanged across a stall
    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && m_axis_tvalid)
        else $error("stalled result changed");

endmodule

// ----- bench/three_point_curvature_top_tb.sv -----
// ---------------------------------------------------------------------------
// three_point_curvature_top_tb
// Drives point triples into the curvature pipeline and checks every result
// against an exact integer curvature computed in the bench.
// ---------------------------------------------------------------------------
module three_point_curvature_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] curv;
        logic        degen;
    } curv_res_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata;   // first_x, first_y, second_x, second_y, third_x, third_y
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [31:0]  m_axis_tdata;   // curvature
    logic         m_axis_tuser;   // degenerate

    curv_res_t curv_q[$];
    int        err_cnt = 0;
    int        hold_cycles = 0;
    bit        stall_on = 1'b1;

    three_point_curvature_top DUT (.*);

    always begin
        i_clk = 1'b0; #6;
        i_clk = 1'b1; #6;
    end

    function automatic logic [33:0] isqrt66(logic [65:0] s);
        logic [33:0] r;
        logic [33:0] c;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            c = r | (34'd1 << b);
            if ({34'd0, c} * {34'd0, c} <= {2'd0, s}) r = c;
        end
        return r;
    endfunction

    function automatic logic [33:0] side_len(logic signed [31:0] ax, logic signed [31:0] ay,
                                              logic signed [31:0] bx, logic signed [31:0] by);
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic [65:0]        s;
        dx = ax - bx;
        dy = ay - by;
        s = 66'(dx * dx) + 66'(dy * dy);
        return isqrt66(s);
    endfunction

    function automatic curv_res_t menger_curv(logic [191:0] d);
        logic signed [31:0]  x1, y1, x2, y2, x3, y3;
        logic [33:0]         d12, d23, d13;
        logic signed [67:0]  cr;
        logic [66:0]         cabs;
        logic [255:0]        num, den;
        curv_res_t           r;
        {y3, x3, y2, x2, y1, x1} = d;
        d12 = side_len(x1, y1, x2, y2);
        d23 = side_len(x2, y2, x3, y3);
        d13 = side_len(x1, y1, x3, y3);
        if (d12 == 0 || d23 == 0 || d13 == 0) begin
            r.curv = '0;
            r.degen = 1'b1;
            return r;
        end
        cr = 68'(x2 - x1) * 68'(y3 - y1) - 68'(y2 - y1) * 68'(x3 - x1);
        cabs = cr < 0 ? 67'(-cr) : 67'(cr);
        num = 256'(cabs) << (1 + tpc_pkg::COORD_FRAC_BITS + tpc_pkg::CURV_FRAC_BITS);
        den = 256'(d12) * 256'(d23) * 256'(d13);
        r.degen = 1'b0;
        if (num >= (den << 32)) r.curv = 32'hFFFF_FFFF;
        else r.curv = 32'(num / den);
        return r;
    endfunction

    // valid stays high on return; the caller drops it
    task automatic send_triple(logic [191:0] d);
        s_axis_tdata  <= d;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        curv_q.insert(curv_q.size(), menger_curv(d));
        @(negedge i_clk);
    endtask

    // send with random gap after bursts
    int burst_left = 0;
    task automatic send_paced(logic [191:0] d);
        int gap;
        s_axis_tdata  <= d;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        curv_q.insert(curv_q.size(), menger_curv(d));
        @(negedge i_clk);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    task automatic wait_drained();
        while (curv_q.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2000)) - 1000);
            2: return 32'($signed($urandom_range(0, 65536 * 40)) - 65536 * 20);
            3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                            : 32'h8000_0000 + $urandom_range(0, 3);
            default: return 32'($signed($urandom_range(0, 20)) - 10) <<< $urandom_range(0, 28);
        endcase
    endfunction

    function automatic logic [191:0] rnd_triple();
        logic [31:0] x1, y1, x2, y2, x3, y3;
        int k;
        x1 = rnd_coord(); y1 = rnd_coord();
        x2 = rnd_coord(); y2 = rnd_coord();
        x3 = rnd_coord(); y3 = rnd_coord();
        k = $urandom_range(0, 9);
        if (k == 0) begin
            x2 = x1; y2 = y1;                   // coincident pair
        end else if (k == 1) begin
            x3 = x2 + (x2 - x1); y3 = y2 + (y2 - y1);   // collinear
        end else if (k == 2) begin
            x2 = x1 + $urandom_range(0, 4) - 2; y2 = y1 + $urandom_range(0, 4) - 2;
            x3 = x1 + $urandom_range(0, 4) - 2; y3 = y1 + $urandom_range(0, 4) - 2;
        end
        return {y3, x3, y2, x2, y1, x1};
    endfunction

    task automatic test_directed();
        logic [31:0] mx, mn;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        send_triple('0);
        send_triple({32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'd0});
        send_triple({32'h0001_0000, 32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'd0});
        send_triple({32'd0, 32'h0002_0000, 32'd0, 32'h0001_0000, 32'd0, 32'd0});
        send_triple({32'd1, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0});
        send_triple({32'd2, 32'd1, 32'd0, 32'd1, 32'd0, 32'd0});
        send_triple({mx, mx, mn, mn, mx, mn});
        send_triple({mn, mx, mx, mn, mn, mn});
        send_triple({mx, mn, mn, mx, mx, mx});
        send_triple({mx, mx, mx, mx, mn, mn});
        send_triple({mn, mn, mx, mx, mn, mn});
        send_triple({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd1, 32'd1});
        send_triple({32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'h1234_5678, 32'h8765_4321});
        send_triple({32'd0, mx, mn, 32'd0, 32'd0, 32'd0});
        send_triple({32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                     32'h0000_0000, 32'h0000_0001});
        s_axis_tvalid <= 1'b0;
        wait_drained();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) send_paced(rnd_triple());
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
    endtask

    // receiver blocked for a long stretch while items keep coming
    task automatic test_backpressure();
        hold_cycles = 300;
        for (int i = 0; i < 200; i++) send_triple(rnd_triple());
        s_axis_tvalid <= 1'b0;
        wait_drained();
    endtask

    // receiver stall pattern; a held-off counter forces long stretches
    always @(negedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else if (!stall_on) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge i_clk) begin
        curv_res_t e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (curv_q.size() == 0) begin
                $error("result with nothing expected: curvature %h", m_axis_tdata);
                err_cnt++;
            end else begin
                e = curv_q.pop_front();
                if (m_axis_tdata !== e.curv) begin
                    $error("curvature exp %h got %h", e.curv, m_axis_tdata);
                    err_cnt++;
                end
                if (m_axis_tuser !== e.degen) begin
                    $error("degenerate exp %b got %b", e.degen, m_axis_tuser);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(500);
        wait_drained();                  // sender pauses until all is back
        test_backpressure();
        stall_on = 1'b0;
        test_random(250);
        stall_on = 1'b1;
        test_random(300);
        wait_drained();
        repeat (100) @(negedge i_clk);
        if (err_cnt == 0 && curv_q.size() == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule
